// ===== rtl/bitstream_header_parser_defines.svh =====
// assertion macros shared by the bitstream header parser rtl
`ifndef BITSTREAM_HEADER_PARSER_DEFINES_SVH
`define BITSTREAM_HEADER_PARSER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define BHP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define BHP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/bhp_pkg.sv =====
// types, constants and magic table for the bitstream header parser
`default_nettype none

package bhp_pkg;

    localparam int MAGIC_LENGTH   = 13;
    localparam int SKIPPED_CHUNKS = 4;

    localparam int POS_W   = 4;
    localparam int CHUNK_W = 3;
    localparam int REM_W   = 16;
    localparam int SIZE_W  = 32;
    localparam int BYTE_W  = 8;

    localparam logic [BYTE_W-1:0] MAGIC_TABLE [16] = '{
        8'h00, 8'h09, 8'h0F, 8'hF0, 8'h0F, 8'hF0, 8'h0F, 8'hF0,
        8'h0F, 8'hF0, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00
    };

    typedef enum logic [2:0] {
        PH_MAGIC   = 3'd0,
        PH_DESIG   = 3'd1,
        PH_LENGTH  = 3'd2,
        PH_DATA    = 3'd3,
        PH_FINAL   = 3'd4,
        PH_PAYLOAD = 3'd5,
        PH_ERROR   = 3'd6
    } t_phase;

    typedef enum logic [2:0] {
        ST_HEADER   = 3'd0,
        ST_DONE     = 3'd1,
        ST_PAYLOAD  = 3'd2,
        ST_MISMATCH = 3'd3,
        ST_TRUNC    = 3'd4
    } t_status;

    typedef struct packed {
        t_phase              phase;
        logic [POS_W-1:0]    byte_position;
        logic [CHUNK_W-1:0]  chunk_number;
        logic [REM_W-1:0]    chunk_remaining;
        logic [SIZE_W-1:0]   size_accumulator;
    } t_parse_state;

    localparam t_parse_state PARSE_RESET = '{
        phase:            PH_MAGIC,
        byte_position:    '0,
        chunk_number:     '0,
        chunk_remaining:  '0,
        size_accumulator: '0
    };

endpackage

`default_nettype wire

// ===== rtl/bhp_if.sv =====
// valid/ready channel interfaces for parser input bytes and results
`default_nettype none

interface bhp_in_if
    import bhp_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              end_of_file;

    modport source (output valid, output data_byte, output end_of_file, input ready);
    modport sink   (input valid, input data_byte, input end_of_file, output ready);
endinterface

interface bhp_out_if
    import bhp_pkg::*;
;
    logic              valid;
    logic              ready;
    t_status           status;
    logic [SIZE_W-1:0] config_size;
    logic [BYTE_W-1:0] payload_byte;

    modport source (output valid, output status, output config_size, output payload_byte,
                    input ready);
    modport sink   (input valid, input status, input config_size, input payload_byte,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/bhp_step.sv =====
// one parse step: next state and result for one byte
`default_nettype none

module bhp_step
    import bhp_pkg::*;
(
    input  t_parse_state      i_state,
    input  logic [BYTE_W-1:0] i_data_byte,
    input  logic              i_end_of_file,
    output t_parse_state      o_next,
    output t_status           o_status,
    output logic [SIZE_W-1:0] o_config_size,
    output logic [BYTE_W-1:0] o_payload_byte
);

    t_parse_state       step;
    t_status            status;
    logic [POS_W:0]     pos_inc;
    logic [CHUNK_W-1:0] chunk_inc;
    logic [REM_W-1:0]   rem_shift;
    logic [REM_W-1:0]   rem_dec;
    logic [SIZE_W-1:0]  acc_shift;
    t_phase             after_chunk;
    t_phase             after_magic;

    assign pos_inc   = {1'b0, i_state.byte_position} + (POS_W+1)'(1);
    assign chunk_inc = i_state.chunk_number + CHUNK_W'(1);
    assign rem_shift = {i_state.chunk_remaining[REM_W-BYTE_W-1:0], i_data_byte};
    assign rem_dec   = i_state.chunk_remaining - REM_W'(1);
    assign acc_shift = {i_state.size_accumulator[SIZE_W-BYTE_W-1:0], i_data_byte};

    // chunk counter wraps at its width before the compare
    assign after_chunk = (chunk_inc >= CHUNK_W'(SKIPPED_CHUNKS)) ? PH_FINAL : PH_DESIG;
    assign after_magic = (SKIPPED_CHUNKS == 0) ? PH_FINAL : PH_DESIG;

    always_comb begin
        step           = i_state;
        status         = ST_HEADER;
        o_config_size  = '0;
        o_payload_byte = '0;
        case (i_state.phase)
            PH_MAGIC: begin
                if (i_data_byte != MAGIC_TABLE[i_state.byte_position]) begin
                    status     = ST_MISMATCH;
                    step.phase = PH_ERROR;
                end else if (pos_inc >= (POS_W+1)'(MAGIC_LENGTH)) begin
                    step.byte_position = '0;
                    step.chunk_number  = '0;
                    step.phase         = after_magic;
                end else begin
                    step.byte_position = pos_inc[POS_W-1:0];
                end
            end
            PH_DESIG: begin
                step.byte_position   = '0;
                step.chunk_remaining = '0;
                step.phase           = PH_LENGTH;
            end
            PH_LENGTH: begin
                step.chunk_remaining = rem_shift;
                if (i_state.byte_position == '0) begin
                    step.byte_position = POS_W'(1);
                end else if (rem_shift == '0) begin
                    // zero-length chunk ends right after its length field
                    step.byte_position = '0;
                    step.chunk_number  = chunk_inc;
                    step.phase         = after_chunk;
                end else begin
                    step.byte_position = '0;
                    step.phase         = PH_DATA;
                end
            end
            PH_DATA: begin
                step.chunk_remaining = rem_dec;
                if (rem_dec == '0) begin
                    step.byte_position = '0;
                    step.chunk_number  = chunk_inc;
                    step.phase         = after_chunk;
                end
            end
            PH_FINAL: begin
                if (i_state.byte_position == '0) begin
                    // designator byte of the size chunk
                    step.size_accumulator = '0;
                    step.byte_position    = POS_W'(1);
                end else begin
                    step.size_accumulator = acc_shift;
                    if (i_state.byte_position >= POS_W'(4)) begin
                        status             = ST_DONE;
                        o_config_size      = acc_shift;
                        step.byte_position = '0;
                        step.phase         = PH_PAYLOAD;
                    end else begin
                        step.byte_position = pos_inc[POS_W-1:0];
                    end
                end
            end
            PH_PAYLOAD: begin
                status         = ST_PAYLOAD;
                o_payload_byte = i_data_byte;
            end
            default: begin
                status = ST_MISMATCH;
            end
        endcase
    end

    // file end restarts parsing; an unfinished header reads as truncated
    always_comb begin
        o_next   = step;
        o_status = status;
        if (i_end_of_file) begin
            o_next = PARSE_RESET;
            if (status == ST_HEADER) begin
                o_status = ST_TRUNC;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/bitstream_header_parser.sv =====
// bitstream header parser top level: input register, parse step, result register
//
//  channel  | dir | payload                              | handshake
//  i_in     | in  | data_byte[7:0], end_of_file          | valid/ready
//  o_out    | out | status[2:0], config_size[31:0],      | valid/ready
//           |     | payload_byte[7:0]                    |
//
// one beat in, one beat out; a new byte can be taken every cycle while o_out is not stalled
// a byte is held in the input register, then goes through the parse step into the result register
// the parse state advances as a byte leaves the input register, so bytes chain back to back
// a stall on o_out holds the result register; the input register still takes one more beat
// synchronous active-low reset returns the parser to the magic check with both stages empty
`default_nettype none

`include "bitstream_header_parser_defines.svh"

module bitstream_header_parser
    import bhp_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    bhp_in_if.sink    i_in,
    bhp_out_if.source o_out
);

    logic              r_s1_valid;
    logic [BYTE_W-1:0] r_s1_data_byte;
    logic              r_s1_end_of_file;
    t_parse_state      r_state;
    logic              r_out_valid;
    t_status           r_out_status;
    logic [SIZE_W-1:0] r_out_config_size;
    logic [BYTE_W-1:0] r_out_payload_byte;

    t_parse_state      n_state;
    t_status           n_status;
    logic [SIZE_W-1:0] n_config_size;
    logic [BYTE_W-1:0] n_payload_byte;

    logic s1_adv;
    logic in_fire;

    assign s1_adv     = r_s1_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_s1_valid || s1_adv;
    assign in_fire    = i_in.valid && i_in.ready;

    bhp_step u_step (
        .i_state        (r_state),
        .i_data_byte    (r_s1_data_byte),
        .i_end_of_file  (r_s1_end_of_file),
        .o_next         (n_state),
        .o_status       (n_status),
        .o_config_size  (n_config_size),
        .o_payload_byte (n_payload_byte)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= PARSE_RESET;
        end else begin
            if (in_fire) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_data_byte   <= i_in.data_byte;
            r_s1_end_of_file <= i_in.end_of_file;
        end
        if (s1_adv) begin
            r_out_status       <= n_status;
            r_out_config_size  <= n_config_size;
            r_out_payload_byte <= n_payload_byte;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.status       = r_out_status;
    assign o_out.config_size  = r_out_config_size;
    assign o_out.payload_byte = r_out_payload_byte;

    `BHP_ASSERT_NOW(a_size_only_when_done, r_out_valid && (r_out_status != ST_DONE), r_out_config_size == '0, "config_size set without header complete")
    `BHP_ASSERT_NOW(a_pay_only_in_payload, r_out_valid && (r_out_status != ST_PAYLOAD), r_out_payload_byte == '0, "payload_byte set outside payload")
    `BHP_ASSERT_NEXT(a_eof_restarts, s1_adv && r_s1_end_of_file, r_state == PARSE_RESET, "file end did not restart parsing")
    `BHP_ASSERT_NEXT(a_payload_forwarded, s1_adv && (r_state.phase == PH_PAYLOAD), r_out_valid && (r_out_status == ST_PAYLOAD), "payload phase byte not forwarded")

endmodule

`default_nettype wire
